// ===== design/afr_pkg.sv =====
// Shared types, codes and helpers for the ASCII hex frame receiver.
package afr_pkg;

    localparam int AFR_NODES = 8;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] HEX_TEN = 8'd10;

    typedef enum logic [1:0] {
        ACT_ADDR = 2'd0,
        ACT_DATA = 2'd1,
        ACT_TICK = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REG_NODE_ADDRESS   = 2'd0,
        REG_IS_MASTER      = 2'd1,
        REG_USER_TYPE_CODE = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_POK = 3'd0,
        ST_ROK = 3'd1,
        ST_TMO = 3'd2,
        ST_ERA = 3'd3,
        ST_CAN = 3'd4,
        ST_TIP = 3'd5,
        ST_ESC = 3'd6,
        ST_OVR = 3'd7
    } status_t;

    typedef struct packed {
        logic [3:0] node_address;
        logic       is_master;
        logic       user_type_code;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        status_t    status;
        logic [7:0] data_byte;
        logic [7:0] hw_source;
        logic       message_type;
        logic [7:0] source_node;
        logic [7:0] dest_node;
        logic [7:0] payload_length;
        logic [7:0] master_address;
    } res_t;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        if (c > CH_NINE)
            return c - CH_A + HEX_TEN;
        return c - CH_ZERO;
    endfunction

endpackage

// ===== design/afr_frame.sv =====
// Frame parser: hex pair decode, checksum, field capture and status generation.
module afr_frame #(
    parameter int NODES = afr_pkg::AFR_NODES
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  logic [1:0]     action,
    input  logic [7:0]     char_in,
    input  logic [2:0]     polled_node,
    input  afr_pkg::cfg_t  cfg,
    output logic           res_valid,
    output afr_pkg::res_t  res
);
    import afr_pkg::*;

    localparam int         IDX_W     = $clog2(NODES);
    localparam logic [8:0] NODES_LIM = 9'(NODES);

    typedef enum logic [2:0] {
        PH_IDLE, PH_HWSRC, PH_TYPE, PH_SRC, PH_DEST, PH_LEN, PH_DATA, PH_CSUM
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [7:0]         sum_reg, sum_next;
    logic [3:0]         high_reg, high_next;
    logic               pair_reg, pair_next;
    logic [7:0]         left_reg, left_next;
    logic [7:0]         hw_reg, hw_next;
    logic               type_reg, type_next;
    logic [7:0]         src_reg, src_next;
    logic [7:0]         dest_reg, dest_next;
    logic [7:0]         len_reg, len_next;
    logic [NODES-1:0]   full_reg, full_next;
    logic [7:0]         master_reg, master_next;

    logic [7:0] own;
    logic [7:0] hv;
    logic [7:0] pair_byte;
    logic [7:0] pol8;
    logic [7:0] left_dec;
    logic       finish;
    status_t    fin_status;

    assign own       = {4'b0, cfg.node_address} + CH_ZERO;
    assign hv        = hex_value(char_in);
    assign pair_byte = {high_reg, 4'b0} + hv;
    assign pol8      = {5'b0, polled_node};
    assign left_dec  = left_reg - 8'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        high_next   = high_reg;
        pair_next   = pair_reg;
        left_next   = left_reg;
        hw_next     = hw_reg;
        type_next   = type_reg;
        src_next    = src_reg;
        dest_next   = dest_reg;
        len_next    = len_reg;
        full_next   = full_reg;
        master_next = master_reg;
        finish      = 1'b0;
        fin_status  = ST_POK;
        res_valid   = 1'b0;
        res         = '0;

        if (take)
        begin
            if (phase_reg == PH_IDLE)
            begin
                unique case (action_t'(action))
                    ACT_TICK:
                    begin
                        finish     = 1'b1;
                        fin_status = ST_TMO;
                    end
                    ACT_ADDR:
                    begin
                        if (cfg.is_master && ({6'b0, polled_node} < NODES_LIM))
                            full_next[pol8[IDX_W-1:0]] = 1'b0;
                        if (cfg.is_master && (char_in != own))
                        begin
                            finish     = 1'b1;
                            fin_status = ST_ERA;
                        end
                        else if (char_in == own)
                        begin
                            phase_next = PH_HWSRC;
                            sum_next   = {4'b0, cfg.node_address};
                            high_next  = '0;
                            pair_next  = 1'b0;
                            left_next  = '0;
                            hw_next    = '0;
                            type_next  = 1'b0;
                            src_next   = '0;
                            dest_next  = '0;
                            len_next   = '0;
                        end
                    end
                    ACT_DATA:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                unique case (action_t'(action))
                    ACT_TICK:
                    begin
                        finish     = 1'b1;
                        fin_status = ST_CAN;
                    end
                    ACT_ADDR, ACT_DATA:
                    begin
                        if (char_in != CH_LF)
                        begin
                            if (!pair_reg)
                            begin
                                high_next = hv[3:0];
                                pair_next = 1'b1;
                            end
                            else
                            begin
                                pair_next = 1'b0;
                                unique case (phase_reg)
                                    PH_HWSRC:
                                    begin
                                        hw_next  = pair_byte;
                                        sum_next = sum_reg + pair_byte;
                                        if (!cfg.is_master)
                                            master_next = pair_byte;
                                        phase_next = PH_TYPE;
                                    end
                                    PH_TYPE:
                                    begin
                                        if (pair_byte > 8'd1)
                                        begin
                                            finish     = 1'b1;
                                            fin_status = ST_TIP;
                                        end
                                        else
                                        begin
                                            type_next  = pair_byte[0];
                                            sum_next   = sum_reg + pair_byte;
                                            phase_next = (pair_byte[0] != cfg.user_type_code)
                                                         ? PH_CSUM : PH_SRC;
                                        end
                                    end
                                    PH_SRC:
                                    begin
                                        src_next   = pair_byte;
                                        sum_next   = sum_reg + pair_byte;
                                        phase_next = PH_DEST;
                                    end
                                    PH_DEST:
                                    begin
                                        dest_next  = pair_byte;
                                        sum_next   = sum_reg + pair_byte;
                                        phase_next = PH_LEN;
                                        if (cfg.is_master && ({1'b0, pair_byte} < NODES_LIM)
                                            && full_reg[pair_byte[IDX_W-1:0]])
                                        begin
                                            finish     = 1'b1;
                                            fin_status = ST_OVR;
                                        end
                                    end
                                    PH_LEN:
                                    begin
                                        len_next   = pair_byte;
                                        sum_next   = sum_reg + pair_byte;
                                        left_next  = pair_byte;
                                        phase_next = (pair_byte != 8'd0) ? PH_DATA : PH_CSUM;
                                    end
                                    PH_DATA:
                                    begin
                                        sum_next      = sum_reg + pair_byte;
                                        left_next     = left_dec;
                                        res_valid     = 1'b1;
                                        res.data_byte = pair_byte;
                                        if (left_dec == 8'd0)
                                            phase_next = PH_CSUM;
                                    end
                                    PH_CSUM:
                                    begin
                                        finish = 1'b1;
                                        if (pair_byte != sum_reg)
                                            fin_status = ST_ESC;
                                        else if (type_reg == cfg.user_type_code)
                                        begin
                                            fin_status = ST_ROK;
                                            if ({1'b0, dest_reg} < NODES_LIM)
                                                full_next[dest_reg[IDX_W-1:0]] = 1'b1;
                                        end
                                        else
                                            fin_status = ST_POK;
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (finish)
        begin
            res_valid  = 1'b1;
            res.kind   = 1'b1;
            res.status = fin_status;
        end
        res.hw_source      = hw_next;
        res.message_type   = type_next;
        res.source_node    = src_next;
        res.dest_node      = dest_next;
        res.payload_length = len_next;
        res.master_address = master_next;

        if (finish)
        begin
            phase_next = PH_IDLE;
            sum_next   = '0;
            high_next  = '0;
            pair_next  = 1'b0;
            left_next  = '0;
            hw_next    = '0;
            type_next  = 1'b0;
            src_next   = '0;
            dest_next  = '0;
            len_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            sum_reg    <= '0;
            high_reg   <= '0;
            pair_reg   <= 1'b0;
            left_reg   <= '0;
            hw_reg     <= '0;
            type_reg   <= 1'b0;
            src_reg    <= '0;
            dest_reg   <= '0;
            len_reg    <= '0;
            full_reg   <= '0;
            master_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            sum_reg    <= sum_next;
            high_reg   <= high_next;
            pair_reg   <= pair_next;
            left_reg   <= left_next;
            hw_reg     <= hw_next;
            type_reg   <= type_next;
            src_reg    <= src_next;
            dest_reg   <= dest_next;
            len_reg    <= len_next;
            full_reg   <= full_next;
            master_reg <= master_next;
        end
    end

endmodule

// ===== design/afr_outq.sv =====
// Output register with one skid word behind it.
module afr_outq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  afr_pkg::res_t push_data,
    input  logic          out_stall,
    output logic          out_valid,
    output afr_pkg::res_t out_data,
    output logic          full
);
    import afr_pkg::*;

    logic main_v_reg, main_v_next;
    logic skid_v_reg, skid_v_next;
    res_t main_reg, main_next;
    res_t skid_reg, skid_next;
    logic open_slot;

    assign open_slot = !main_v_reg || !out_stall;

    always_comb
    begin
        main_v_next = main_v_reg;
        skid_v_next = skid_v_reg;
        main_next   = main_reg;
        skid_next   = skid_reg;
        if (open_slot)
        begin
            if (skid_v_reg)
            begin
                main_next   = skid_reg;
                main_v_next = 1'b1;
                skid_next   = push_data;
                skid_v_next = push;
            end
            else
            begin
                main_next   = push_data;
                main_v_next = push;
            end
        end
        else if (push)
        begin
            skid_next   = push_data;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_v_reg;
    assign out_data  = main_reg;
    assign full      = skid_v_reg;

endmodule

// ===== design/ascii_hex_frame_receiver_top.sv =====
// Top level of the ASCII hex frame receiver: configuration, parser and output buffer.
// Each result word is registered in the output buffer: the output register, or the skid word behind it.
// Throughput: one character per cycle; the input stalls only while the skid word is full.
// Reset (rst_n low, asynchronous): parser idle, buffer-full flags and learned master clear,
// output empty, node_address 1, is_master 0, user_type_code 1.
module ascii_hex_frame_receiver_top #(
    parameter int NODES = afr_pkg::AFR_NODES
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [7:0] char_in,
    input  logic [2:0] polled_node,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [2:0] status,
    output logic [7:0] data_byte,
    output logic [7:0] hw_source,
    output logic       message_type,
    output logic [7:0] source_node,
    output logic [7:0] dest_node,
    output logic [7:0] payload_length,
    output logic [7:0] master_address,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);
    import afr_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic take;
    logic res_valid;
    res_t res;
    res_t q_data;
    logic q_full;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_NODE_ADDRESS:   cfg_next.node_address   = cfg_data;
                REG_IS_MASTER:      cfg_next.is_master      = cfg_data[0];
                REG_USER_TYPE_CODE: cfg_next.user_type_code = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_address   <= 4'd1;
            cfg_reg.is_master      <= 1'b0;
            cfg_reg.user_type_code <= 1'b1;
        end
        else
            cfg_reg <= cfg_next;
    end

    assign in_stall = q_full;
    assign take     = in_valid && !q_full;

    afr_frame #(
        .NODES(NODES)
    ) u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .action      (action),
        .char_in     (char_in),
        .polled_node (polled_node),
        .cfg         (cfg_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    afr_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (q_data),
        .full      (q_full)
    );

    assign kind           = q_data.kind;
    assign status         = q_data.status;
    assign data_byte      = q_data.data_byte;
    assign hw_source      = q_data.hw_source;
    assign message_type   = q_data.message_type;
    assign source_node    = q_data.source_node;
    assign dest_node      = q_data.dest_node;
    assign payload_length = q_data.payload_length;
    assign master_address = q_data.master_address;
    assign last           = q_data.kind;

`ifndef NO_ASSERTIONS
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("skid word held while output register empty");

    a_status_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind) |-> (data_byte == 8'd0))
        else $error("status word carries a data byte");

    a_data_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kind) |-> (status == ST_POK))
        else $error("data word carries a nonzero status");
`endif

endmodule

// ===== sim/tb.sv =====
// Testbench for the ASCII hex frame receiver: random frames checked against an in-bench predictor.
`timescale 1ns / 1ps

module tb;
    import afr_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef enum logic [3:0] {
        RX_IDLE,
        RX_HWSRC,
        RX_TYPE,
        RX_SRC,
        RX_DEST,
        RX_LEN,
        RX_DATA,
        RX_CSUM
    } rx_phase_t;

    typedef struct {
        logic [1:0] act;
        logic [7:0] ch;
        logic [2:0] polled;
    } bus_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] action = ACT_NONE;
    logic [7:0] char_in = 8'h00;
    logic [2:0] polled_node = 3'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       kind;
    logic [2:0] status;
    logic [7:0] data_byte;
    logic [7:0] hw_source;
    logic       message_type;
    logic [7:0] source_node;
    logic [7:0] dest_node;
    logic [7:0] payload_length;
    logic [7:0] master_address;
    logic       last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = REG_NODE_ADDRESS;
    logic [3:0] cfg_data = 4'd0;

    ascii_hex_frame_receiver_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .char_in        (char_in),
        .polled_node    (polled_node),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .status         (status),
        .data_byte      (data_byte),
        .hw_source      (hw_source),
        .message_type   (message_type),
        .source_node    (source_node),
        .dest_node      (dest_node),
        .payload_length (payload_length),
        .master_address (master_address),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    // register copies
    logic [3:0] m_node = 4'd1;
    logic       m_master = 1'b0;
    logic       m_utc = 1'b1;

    // receiver state copy
    rx_phase_t            rx_phase = RX_IDLE;
    logic [7:0]           rx_sum = 8'h00;
    logic [7:0]           rx_hi = 8'h00;
    logic                 rx_half = 1'b0;
    logic [7:0]           rx_left = 8'h00;
    logic [7:0]           f_hw = 8'h00;
    logic [7:0]           f_type = 8'h00;
    logic [7:0]           f_src = 8'h00;
    logic [7:0]           f_dest = 8'h00;
    logic [7:0]           f_len = 8'h00;
    logic [7:0]           mstr = 8'h00;
    logic [AFR_NODES-1:0] bfull = '0;

    bus_char_t pend_q[$];
    res_t      exp_q[$];
    int        n_queued = 0;
    int        n_accepted = 0;
    int        n_fail = 0;
    int        n_data_words = 0;
    int        stat_count[8] = '{default: 0};
    int        cyc = 0;
    bit        noisy = 1'b0;

    function automatic logic [7:0] nibble_of(input logic [7:0] c);
        logic [7:0] n;
        n = (c > CH_NINE) ? 8'(c - CH_A + HEX_TEN) : 8'(c - CH_ZERO);
        return n;
    endfunction

    function automatic void post_word(input logic k, input status_t st, input logic [7:0] d);
        res_t r;
        r.kind           = k;
        r.status         = st;
        r.data_byte      = d;
        r.hw_source      = f_hw;
        r.message_type   = f_type[0];
        r.source_node    = f_src;
        r.dest_node      = f_dest;
        r.payload_length = f_len;
        r.master_address = mstr;
        exp_q.push_back(r);
    endfunction

    function automatic void reset_frame();
        rx_phase = RX_IDLE;
        rx_sum   = 8'h00;
        rx_hi    = 8'h00;
        rx_half  = 1'b0;
        rx_left  = 8'h00;
        f_hw     = 8'h00;
        f_type   = 8'h00;
        f_src    = 8'h00;
        f_dest   = 8'h00;
        f_len    = 8'h00;
    endfunction

    function automatic void end_frame(input status_t st);
        post_word(1'b1, st, 8'h00);
        reset_frame();
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        case (rx_phase)
            RX_HWSRC:
            begin
                f_hw = b;
                rx_sum += b;
                if (!m_master)
                    mstr = b;
                rx_phase = RX_TYPE;
            end
            RX_TYPE:
            begin
                if (b > 8'd1)
                    end_frame(ST_TIP);
                else
                begin
                    f_type = b;
                    rx_sum += b;
                    rx_phase = (b[0] != m_utc) ? RX_CSUM : RX_SRC;
                end
            end
            RX_SRC:
            begin
                f_src = b;
                rx_sum += b;
                rx_phase = RX_DEST;
            end
            RX_DEST:
            begin
                f_dest = b;
                rx_sum += b;
                if (m_master && b < AFR_NODES && bfull[b[2:0]])
                    end_frame(ST_OVR);
                else
                    rx_phase = RX_LEN;
            end
            RX_LEN:
            begin
                f_len = b;
                rx_sum += b;
                rx_left = b;
                rx_phase = (b != 8'd0) ? RX_DATA : RX_CSUM;
            end
            RX_DATA:
            begin
                rx_sum += b;
                post_word(1'b0, ST_POK, b);
                rx_left -= 8'd1;
                if (rx_left == 8'd0)
                    rx_phase = RX_CSUM;
            end
            default:
            begin
                if (b != rx_sum)
                    end_frame(ST_ESC);
                else if (f_type == {7'd0, m_utc})
                begin
                    if (f_dest < AFR_NODES)
                        bfull[f_dest[2:0]] = 1'b1;
                    end_frame(ST_ROK);
                end
                else
                    end_frame(ST_POK);
            end
        endcase
    endfunction

    function automatic void predict_char(input logic [1:0] act, input logic [7:0] ch,
                                         input logic [2:0] polled);
        logic [7:0] own;
        own = {4'd0, m_node} + CH_ZERO;
        if (act == ACT_NONE)
            return;
        if (rx_phase == RX_IDLE)
        begin
            if (act == ACT_TICK)
                end_frame(ST_TMO);
            else if (act == ACT_ADDR)
            begin
                if (m_master)
                    bfull[polled] = 1'b0;
                if (m_master && ch != own)
                    end_frame(ST_ERA);
                else if (ch == own)
                begin
                    reset_frame();
                    rx_sum = {4'd0, m_node};
                    rx_phase = RX_HWSRC;
                end
            end
        end
        else if (act == ACT_TICK)
            end_frame(ST_CAN);
        else if (ch != CH_LF)
        begin
            if (!rx_half)
            begin
                rx_hi = nibble_of(ch);
                rx_half = 1'b1;
            end
            else
            begin
                rx_half = 1'b0;
                absorb_byte({rx_hi[3:0], 4'h0} + nibble_of(ch));
            end
        end
    endfunction

    function automatic void push_char(input logic [1:0] act, input logic [7:0] ch,
                                      input logic [2:0] polled);
        bus_char_t it;
        it.act    = act;
        it.ch     = ch;
        it.polled = polled;
        pend_q.push_back(it);
        n_queued++;
    endfunction

    function automatic void push_data(input logic [7:0] ch);
        logic [1:0] act;
        act = ACT_DATA;
        if (noisy)
        begin
            if ($urandom_range(0, 99) < 2)
                push_char(ACT_DATA, CH_LF, 3'($urandom));
            if ($urandom_range(0, 199) == 0)
                push_char(ACT_TICK, 8'($urandom), 3'($urandom));
            if ($urandom_range(0, 99) == 0)
                ch = 8'($urandom);
            if ($urandom_range(0, 99) < 3)
                act = ACT_ADDR;
        end
        push_char(act, ch, 3'($urandom));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        c = (n < 4'd10) ? CH_ZERO + 8'(n) : CH_A + 8'(n) - HEX_TEN;
        return c;
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        push_data(hex_char(b[7:4]));
        push_data(hex_char(b[3:0]));
    endfunction

    function automatic void push_frame();
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] typ;
        logic [7:0] dst;
        logic [7:0] len;
        logic [7:0] own;
        logic       user;
        int         r;
        int         i;
        own = {4'd0, m_node} + CH_ZERO;
        r = $urandom_range(0, 99);
        push_char(ACT_ADDR, (r < 90) ? own : 8'($urandom_range(CH_ZERO, CH_NINE)),
                  3'($urandom));
        sum = {4'd0, m_node};
        b = 8'($urandom);
        push_byte(b);
        sum += b;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            push_byte(8'($urandom_range(2, 255)));
            return;
        end
        user = (r < 70);
        typ = {7'd0, user ? m_utc : ~m_utc};
        push_byte(typ);
        sum += typ;
        if (user)
        begin
            b = 8'($urandom);
            push_byte(b);
            sum += b;
            dst = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, AFR_NODES - 1))
                                               : 8'($urandom);
            push_byte(dst);
            sum += dst;
            r = $urandom_range(0, 99);
            len = (r < 90) ? 8'($urandom_range(0, 6)) :
                  (r < 99) ? 8'($urandom_range(7, 40)) : 8'($urandom_range(200, 255));
            push_byte(len);
            sum += len;
            for (i = 0; i < len; i++)
            begin
                b = 8'($urandom);
                push_byte(b);
                sum += b;
            end
        end
        if ($urandom_range(0, 99) < 12)
            sum += 8'($urandom_range(1, 255));
        push_byte(sum);
    endfunction

    task automatic drain();
        while (n_accepted != n_queued || exp_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [3:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_NODE_ADDRESS: m_node = val;
            REG_IS_MASTER:    m_master = val[0];
            default:          m_utc = val[0];
        endcase
        @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int goal;
        goal = n_queued + count;
        noisy = 1'b1;
        while (n_queued < goal)
        begin
            if ($urandom_range(0, 9) == 0)
                push_char(2'($urandom), 8'($urandom), 3'($urandom));
            else
                push_frame();
        end
        // close any open frame before the next register change
        push_char(ACT_TICK, 8'($urandom), 3'($urandom));
        drain();
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge clk)
        cyc <= cyc + 1;

    always @(posedge clk)
    begin : driver
        bus_char_t w;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_char(action, char_in, polled_node);
                n_accepted++;
            end
            if (!(in_valid && in_stall))
            begin
                if (pend_q.size() != 0
                    && !((cyc % 3000) >= 600 && $urandom_range(0, 99) < 25))
                begin
                    w = pend_q.pop_front();
                    action      <= w.act;
                    char_in     <= w.ch;
                    polled_node <= w.polled;
                    in_valid    <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        res_t e;
        if (rst_n)
        begin
            out_stall <= (cyc % 3000) >= 600 && $urandom_range(0, 99) < 25;
            if (out_valid && !out_stall)
            begin
                if (exp_q.size() == 0)
                begin
                    $error("result word with nothing expected: kind %0d status %0d",
                           kind, status);
                    n_fail++;
                end
                else
                begin
                    e = exp_q.pop_front();
                    if (e.kind)
                        stat_count[e.status]++;
                    else
                        n_data_words++;
                    check_field("kind", 8'(e.kind), 8'(kind));
                    check_field("status", 8'(e.status), 8'(status));
                    check_field("data_byte", e.data_byte, data_byte);
                    check_field("hw_source", e.hw_source, hw_source);
                    check_field("message_type", 8'(e.message_type), 8'(message_type));
                    check_field("source_node", e.source_node, source_node);
                    check_field("dest_node", e.dest_node, dest_node);
                    check_field("payload_length", e.payload_length, payload_length);
                    check_field("master_address", e.master_address, master_address);
                    check_field("last", 8'(e.kind), 8'(last));
                end
            end
        end
    end

    initial
    begin : stimulus
        static int set_node[6]   = '{0, 9, 9, 0, 5, 3};
        static int set_master[6] = '{1, 0, 1, 0, 1, 0};
        static int set_utc[6]    = '{1, 0, 0, 1, 1, 0};
        int p;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: node 1, slave, user type 1
        push_char(ACT_TICK, 8'h00, 3'd0);
        push_char(ACT_DATA, 8'hFF, 3'd7);
        push_char(ACT_NONE, 8'h31, 3'd7);
        push_char(ACT_ADDR, 8'h35, 3'd5);
        push_char(ACT_ADDR, 8'h31, 3'd0);
        push_byte(8'hFF);
        push_char(ACT_DATA, CH_LF, 3'd2);
        push_byte(8'h01);
        push_byte(8'h00);
        push_byte(8'h03);
        push_byte(8'h01);
        push_byte(8'hA5);
        push_byte(8'hAB);
        push_char(ACT_ADDR, 8'h31, 3'd3);
        push_byte(8'h12);
        push_byte(8'h07);
        push_char(ACT_ADDR, 8'h31, 3'd1);
        push_char(ACT_TICK, 8'h5A, 3'd6);
        drain();
        run_random(100);

        for (p = 0; p < 6; p++)
        begin
            write_reg(REG_NODE_ADDRESS, 4'(set_node[p]));
            write_reg(REG_IS_MASTER, 4'(set_master[p]));
            write_reg(REG_USER_TYPE_CODE, 4'(set_utc[p]));
            run_random(120);
        end

        $display("Ran %0d bus characters over 7 register settings: %0d data bytes checked",
                 n_accepted, n_data_words);
        $display("Frame endings pok %0d rok %0d tmo %0d era %0d can %0d tip %0d esc %0d ovr %0d",
                 stat_count[0], stat_count[1], stat_count[2], stat_count[3],
                 stat_count[4], stat_count[5], stat_count[6], stat_count[7]);
        if (n_fail == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #(10_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
